// File: design/smf_pkg.sv
// Shared types and constants of the sliding median filter.
`default_nettype none

package smf_pkg;

    localparam int SAMPLE_W = 16;

    typedef logic [SAMPLE_W-1:0] sample_t;

endpackage

`default_nettype wire

// File: design/sliding_median_filter.sv
// Sliding median filter: ring of recent samples and registered median output.
//
// Usage: each transaction on the s_ channel carries one unsigned 16-bit sample.
// The sample overwrites the oldest slot of a WINDOW-entry ring, and one
// transaction on the m_ channel returns the middle value of the updated window
// (for an even window, the upper of the two middle values).
// The accepted sample is loaded into the ring; the median of the updated ring
// is then loaded into the output register, once it is empty or being taken,
// from a parallel rank comparator network over the ring, and offered on m_valid.
// Throughput: one sample per cycle, sustained, as long as the receiver keeps
// m_ready high; the ring stage and the output register form a two-entry pipe.
// Stall: with m_ready low the output holds; one more sample is still taken
// into the ring stage, then s_ready drops until the output is taken.
// Reset (aresetn low, synchronous): the ring clears to zero and the write slot
// to the first entry, so the first medians count the zero slots as samples.
`default_nettype none

module sliding_median_filter #(
    parameter int WINDOW = 5
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              s_valid,
    output logic             s_ready,
    input  smf_pkg::sample_t s_sample,
    output logic             m_valid,
    input  wire              m_ready,
    output smf_pkg::sample_t m_median
);
    import smf_pkg::*;

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

    sample_t           ring_reg [WINDOW];
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic              pend_valid_reg;
    logic              out_valid_reg;
    sample_t           median_reg;
    sample_t           median_next;

    logic s_accept;
    logic out_load;

    // Load the output register when it is empty or being taken.
    assign out_load = !out_valid_reg || m_ready;
    assign s_ready  = !pend_valid_reg || out_load;
    assign s_accept = s_valid && s_ready;

    assign slot_next = (slot_reg == LAST_SLOT) ? '0 : (slot_reg + SLOT_W'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < WINDOW; k++) begin
                ring_reg[k] <= '0;
            end
            slot_reg <= '0;
        end else if (s_accept) begin
            for (int k = 0; k < WINDOW; k++) begin
                if (slot_reg == SLOT_W'(k)) begin
                    ring_reg[k] <= s_sample;
                end
            end
            slot_reg <= slot_next;
        end
    end

    smf_rank_select #(
        .WINDOW(WINDOW)
    ) u_select (
        .window_i(ring_reg),
        .median_o(median_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (s_accept) begin
                pend_valid_reg <= 1'b1;
            end else if (out_load) begin
                pend_valid_reg <= 1'b0;
            end
            if (out_load) begin
                out_valid_reg <= pend_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load && pend_valid_reg) begin
            median_reg <= median_next;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_median = median_reg;

    property p_slot_in_range;
        @(posedge aclk) disable iff (!aresetn) slot_reg <= LAST_SLOT;
    endproperty
    a_slot_in_range: assert property (p_slot_in_range)
        else $error("write slot out of range");

    property p_stall_only_when_full;
        @(posedge aclk) disable iff (!aresetn)
            !s_ready |-> (pend_valid_reg && out_valid_reg && !m_ready);
    endproperty
    a_stall_only_when_full: assert property (p_stall_only_when_full)
        else $error("input stalled while the pipe has room");

    property p_accept_fills_ring_stage;
        @(posedge aclk) disable iff (!aresetn) s_accept |=> pend_valid_reg;
    endproperty
    a_accept_fills_ring_stage: assert property (p_accept_fills_ring_stage)
        else $error("accepted sample lost from ring stage");

    property p_slot_advances;
        @(posedge aclk) disable iff (!aresetn)
            s_accept |=> (slot_reg != $past(slot_reg)) || (WINDOW == 1);
    endproperty
    a_slot_advances: assert property (p_slot_advances)
        else $error("write slot did not advance");

    property p_output_from_pending;
        @(posedge aclk) disable iff (!aresetn)
            (out_load && !pend_valid_reg) |=> !out_valid_reg;
    endproperty
    a_output_from_pending: assert property (p_output_from_pending)
        else $error("output raised without a pending window");

endmodule

`default_nettype wire

// File: design/smf_rank_select.sv
// Rank-based selection of the middle element of the sample window.
`default_nettype none

module smf_rank_select #(
    parameter int WINDOW = 5
) (
    input  smf_pkg::sample_t window_i [WINDOW],
    output smf_pkg::sample_t median_o
);
    import smf_pkg::*;

    localparam int RANK_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [RANK_W-1:0] MID_RANK = RANK_W'(WINDOW / 2);

    logic [RANK_W-1:0] rank [WINDOW];
    logic [WINDOW-1:0] pick;

    // Rank of entry i: entries that sort ahead of it; equal values break ties by slot.
    always_comb begin
        for (int i = 0; i < WINDOW; i++) begin
            rank[i] = '0;
            for (int j = 0; j < WINDOW; j++) begin
                if ((window_i[j] < window_i[i]) || ((window_i[j] == window_i[i]) && (j < i))) begin
                    rank[i] = rank[i] + RANK_W'(1);
                end
            end
            pick[i] = (rank[i] == MID_RANK);
        end
    end

    // Ranks are a permutation, so exactly one entry is picked.
    always_comb begin
        median_o = '0;
        for (int i = 0; i < WINDOW; i++) begin
            median_o = median_o | (window_i[i] & {SAMPLE_W{pick[i]}});
        end
    end

endmodule

`default_nettype wire
